FILE: rtl/slts_pkg.sv
// Shared types, constants and the breathing duty table for the status LED
// tick sequencer. No dependencies; every other rtl file uses this package.
`default_nettype none

package slts_pkg;

  // Breathing table length and red flash pairs before power off
  localparam int BREATH_STEPS = 50;
  localparam int FLASH_COUNT  = 5;

  localparam int BREATH_W = 6;
  localparam int FLASH_KW = (2 * FLASH_COUNT > 1) ? $clog2(2 * FLASH_COUNT) : 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register reset values
  localparam logic [31:0] PWM_PERIOD_RST     = 32'd1000000;
  localparam logic [6:0]  CRITICAL_LEVEL_RST = 7'd2;
  localparam logic [6:0]  LOW_LEVEL_RST      = 7'd10;
  localparam logic [3:0]  STATUS_DIVIDER_RST = 4'd6;
  localparam logic [3:0]  BOOT_WINDOWS_RST   = 4'd10;

  // Period split into quotient and remainder by one hundred
  localparam int          PQ_W     = 26;
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;  // 2^37 / 100, rounded up
  localparam logic [12:0] BD_MAGIC     = 13'd5243;      // 2^19 / 100, rounded up
  localparam logic [PQ_W-1:0] PQUOT_RST = PQ_W'(PWM_PERIOD_RST / 100);
  localparam logic [6:0]      PREM_RST  = 7'(PWM_PERIOD_RST % 100);

  localparam logic [3:0] WINDOW_MAX = 4'd15;

  typedef enum logic [2:0] {
    CFG_PWM_PERIOD     = 3'd0,
    CFG_CRITICAL_LEVEL = 3'd1,
    CFG_LOW_LEVEL      = 3'd2,
    CFG_STATUS_DIVIDER = 3'd3,
    CFG_BOOT_WINDOWS   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic       link_up;
    logic [6:0] battery_percent;
    logic       usb_power;
    logic       charge_done;
  } in_word_t;

  typedef struct packed {
    logic [31:0] power_pulse;
    logic        bt_led;
    logic        red_led;
    logic        green_led;
    logic        power_off;
    logic        last;
  } out_word_t;

  // Level thresholds and status timing used by the front
  typedef struct packed {
    logic [6:0] critical_level;
    logic [6:0] low_level;
    logic [3:0] status_divider;
    logic [3:0] boot_windows;
  } front_cfg_t;

  // One classified tick handed from front to back
  typedef struct packed {
    logic       shutdown;
    logic [6:0] duty;
    logic       bt;
    logic       red;
    logic       green;
  } cmd_t;

  // Duty in percent for each breathing step; steps past the shape are dark
  function automatic logic [6:0] duty_of(input logic [BREATH_W-1:0] idx);
    logic [6:0] d;
    case (idx)
      6'd0:    d = 7'd0;
      6'd1:    d = 7'd2;
      6'd2:    d = 7'd8;
      6'd3:    d = 7'd18;
      6'd4:    d = 7'd32;
      6'd5:    d = 7'd50;
      6'd6:    d = 7'd68;
      6'd7:    d = 7'd82;
      6'd8:    d = 7'd92;
      6'd9:    d = 7'd98;
      6'd10:   d = 7'd100;
      6'd11:   d = 7'd98;
      6'd12:   d = 7'd92;
      6'd13:   d = 7'd82;
      6'd14:   d = 7'd68;
      6'd15:   d = 7'd50;
      6'd16:   d = 7'd32;
      6'd17:   d = 7'd18;
      6'd18:   d = 7'd8;
      6'd19:   d = 7'd2;
      default: d = 7'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/slts_front.sv
// Front end of the status LED tick sequencer: accepts tick words, keeps breathing
// and status state and pushes one command per tick until halted. Uses slts_pkg.
`default_nettype none

module slts_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire slts_pkg::in_word_t  in_data,
  input  wire slts_pkg::front_cfg_t cfg,
  input  wire logic                q_full,
  output logic                     push,
  output slts_pkg::cmd_t           push_cmd
);

  logic [slts_pkg::BREATH_W-1:0] breath_index, breath_index_next;
  logic [3:0] divider_phase, divider_phase_next;
  logic [3:0] window_count, window_count_next;
  logic       blink_phase, blink_phase_next;
  logic       bt_lit, bt_lit_next;
  logic       red_lit, red_lit_next;
  logic       green_lit, green_lit_next;
  logic       halted, halted_next;

  logic       accept;
  logic [3:0] div_eff;
  logic [4:0] phase_inc;
  logic [slts_pkg::BREATH_W:0] breath_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign div_eff  = (cfg.status_divider == 4'd0) ? 4'd1 : cfg.status_divider;
  assign phase_inc  = {1'b0, divider_phase} + 5'd1;
  assign breath_inc = {1'b0, breath_index} + 1'b1;

  always_comb begin
    breath_index_next  = breath_index;
    divider_phase_next = divider_phase;
    window_count_next  = window_count;
    blink_phase_next   = blink_phase;
    bt_lit_next        = bt_lit;
    red_lit_next       = red_lit;
    green_lit_next     = green_lit;
    halted_next        = halted;
    push               = 1'b0;
    push_cmd           = '0;

    if (accept && !halted) begin
      push = 1'b1;
      if ((in_data.battery_percent < cfg.critical_level) && !in_data.usb_power) begin
        // Shutdown: flash with the current lights, then go dark and halt
        push_cmd.shutdown = 1'b1;
        push_cmd.bt       = bt_lit;
        push_cmd.green    = green_lit;
        bt_lit_next       = 1'b0;
        red_lit_next      = 1'b0;
        green_lit_next    = 1'b0;
        halted_next       = 1'b1;
      end else begin
        push_cmd.duty = slts_pkg::duty_of(breath_index);
        if (breath_inc >= (slts_pkg::BREATH_W+1)'(slts_pkg::BREATH_STEPS)) begin
          breath_index_next = '0;
        end else begin
          breath_index_next = breath_inc[slts_pkg::BREATH_W-1:0];
        end

        if (divider_phase == 4'd0) begin
          bt_lit_next = in_data.link_up | blink_phase;
          if (in_data.usb_power) begin
            red_lit_next   = !in_data.charge_done;
            green_lit_next = in_data.charge_done;
          end else if (window_count < cfg.boot_windows) begin
            red_lit_next   = in_data.battery_percent < cfg.low_level;
            green_lit_next = !(in_data.battery_percent < cfg.low_level);
          end else begin
            red_lit_next   = 1'b0;
            green_lit_next = 1'b0;
          end
          blink_phase_next = !blink_phase;
          if (window_count < slts_pkg::WINDOW_MAX) begin
            window_count_next = window_count + 4'd1;
          end
        end

        if (phase_inc >= {1'b0, div_eff}) begin
          divider_phase_next = 4'd0;
        end else begin
          divider_phase_next = phase_inc[3:0];
        end

        push_cmd.bt    = bt_lit_next;
        push_cmd.red   = red_lit_next;
        push_cmd.green = green_lit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      breath_index  <= '0;
      divider_phase <= '0;
      window_count  <= '0;
      blink_phase   <= 1'b0;
      bt_lit        <= 1'b0;
      red_lit       <= 1'b0;
      green_lit     <= 1'b0;
      halted        <= 1'b0;
    end else begin
      breath_index  <= breath_index_next;
      divider_phase <= divider_phase_next;
      window_count  <= window_count_next;
      blink_phase   <= blink_phase_next;
      bt_lit        <= bt_lit_next;
      red_lit       <= red_lit_next;
      green_lit     <= green_lit_next;
      halted        <= halted_next;
    end
  end

  // Halt holds until reset
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("front left the halted state without reset");

endmodule

`default_nettype wire

FILE: rtl/slts_queue.sv
// Short command queue between the front and back of the status LED
// tick sequencer. Uses slts_pkg for the command type and depth.
`default_nettype none

module slts_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire slts_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                nonempty,
  output slts_pkg::cmd_t      pop_cmd
);

  slts_pkg::cmd_t entries [slts_pkg::QUEUE_DEPTH];

  logic [slts_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [slts_pkg::QCNT_W-1:0] count;

  assign full     = (count == slts_pkg::QCNT_W'(slts_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign pop_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !nonempty))
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire

FILE: rtl/slts_back.sv
// Back end of the status LED tick sequencer: splits the PWM period by one
// hundred, scales duty into a pulse and sequences the shutdown flash words.
// Uses slts_pkg.
`default_nettype none

module slts_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [31:0]    pwm_period,
  input  wire logic           period_wr,
  input  wire logic           q_nonempty,
  input  wire slts_pkg::cmd_t q_cmd,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output slts_pkg::out_word_t out_data
);

  // Period split: quotient and remainder by one hundred
  logic [1:0]  split_busy;
  logic [63:0] split_prod;
  logic [slts_pkg::PQ_W-1:0] pquot;
  logic [6:0]  prem;
  logic [slts_pkg::PQ_W-1:0] quot_new;
  logic [31:0] rem_full;

  // Scale stage
  logic           a_valid;
  slts_pkg::cmd_t a_cmd;
  logic [31:0]    a_ad;
  logic [13:0]    a_bd;
  logic [32:0]    ad_full;

  // Output stage and flash sequencer
  logic        en, b_take_a, a_take;
  logic        flash_active;
  logic [slts_pkg::FLASH_KW-1:0] flash_k, flash_k_inc;
  logic        fl_bt, fl_green;
  logic [31:0] pulse_held;
  logic [26:0] bd_prod;
  logic [31:0] pulse_new;

  assign quot_new = split_prod[slts_pkg::PQ_W+36:37];
  assign rem_full = pwm_period - 32'(quot_new * 7'd100);

  always_ff @(posedge clk) begin
    if (rst) begin
      split_busy <= '0;
      pquot      <= slts_pkg::PQUOT_RST;
      prem       <= slts_pkg::PREM_RST;
    end else begin
      split_busy <= {split_busy[0], period_wr};
      if (split_busy[1]) begin
        pquot <= quot_new;
        prem  <= rem_full[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (split_busy[0]) begin
      split_prod <= pwm_period * slts_pkg::DIV100_MAGIC;
    end
  end

  assign en       = !out_valid || !out_stall;
  assign b_take_a = en && !flash_active;
  assign a_take   = !a_valid || b_take_a;
  assign pop      = a_take && q_nonempty && (split_busy == 2'b00);
  assign ad_full  = pquot * q_cmd.duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_take) begin
      a_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_cmd <= q_cmd;
      a_ad  <= ad_full[31:0];
      a_bd  <= prem * q_cmd.duty;
    end
  end

  assign bd_prod     = a_bd * slts_pkg::BD_MAGIC;
  assign pulse_new   = a_ad + {24'd0, bd_prod[26:19]};
  assign flash_k_inc = flash_k + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      flash_active <= 1'b0;
      flash_k      <= '0;
      pulse_held   <= '0;
    end else if (en) begin
      if (flash_active) begin
        out_valid <= 1'b1;
        if (flash_k == slts_pkg::FLASH_KW'(2 * slts_pkg::FLASH_COUNT - 1)) begin
          flash_active <= 1'b0;
        end else begin
          flash_k <= flash_k_inc;
        end
      end else if (a_valid) begin
        out_valid <= 1'b1;
        if (a_cmd.shutdown) begin
          flash_active <= 1'b1;
          flash_k      <= '0;
        end else begin
          pulse_held <= pulse_new;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (flash_active) begin
        if (flash_k == slts_pkg::FLASH_KW'(2 * slts_pkg::FLASH_COUNT - 1)) begin
          out_data <= '{power_pulse: '0, bt_led: 1'b0, red_led: 1'b0,
                        green_led: 1'b0, power_off: 1'b1, last: 1'b1};
        end else begin
          out_data <= '{power_pulse: pulse_held, bt_led: fl_bt, red_led: !flash_k_inc[0],
                        green_led: fl_green, power_off: 1'b0, last: 1'b0};
        end
      end else if (a_valid) begin
        if (a_cmd.shutdown) begin
          fl_bt    <= a_cmd.bt;
          fl_green <= a_cmd.green;
          out_data <= '{power_pulse: pulse_held, bt_led: a_cmd.bt, red_led: 1'b1,
                        green_led: a_cmd.green, power_off: 1'b0, last: 1'b0};
        end else begin
          out_data <= '{power_pulse: pulse_new, bt_led: a_cmd.bt, red_led: a_cmd.red,
                        green_led: a_cmd.green, power_off: 1'b0, last: 1'b1};
        end
      end
    end
  end

  // Nothing leaves the queue while a flash run owns the output and the scale stage is full
  a_no_pop_in_flash: assert property (@(posedge clk) disable iff (rst)
    flash_active && a_valid |-> !pop)
    else $error("command popped into a blocked scale stage");

  // The end of a flash run leaves the power-off word in the output register
  a_flash_ends_off: assert property (@(posedge clk) disable iff (rst)
    $fell(flash_active) |-> (out_valid && out_data.power_off && out_data.last))
    else $error("flash run ended without the power-off word");

endmodule

`default_nettype wire

FILE: rtl/status_led_tick_sequencer_top.sv
// A tick word goes from the front into the queue, then through the scale stage
// to the output register. Throughput: one tick per cycle while the queue is not
// full; a shutdown tick holds the output stage for 2*FLASH_COUNT+1 words, set by
// the flash sequencer. A pwm_period write splits the period by one hundred via
// split_prod into pquot and prem, while the back end takes no command. Reset is
// synchronous: control clears, registers load defaults; ready in the next cycle.
`default_nettype none

module status_led_tick_sequencer_top (
  input  wire logic                clk,
  input  wire logic                rst,
  // tick words
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire slts_pkg::in_word_t  in_data,
  // result words
  output logic                     out_valid,
  input  wire logic                out_stall,
  output slts_pkg::out_word_t      out_data,
  // register writes
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  logic [31:0] pwm_period;
  slts_pkg::front_cfg_t front_cfg;
  logic cfg_wr;
  logic period_wr;

  logic           q_full, q_nonempty, push, pop;
  slts_pkg::cmd_t push_cmd, pop_cmd;

  // Register writes are always taken; cfg_ready is tied high
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign period_wr = cfg_wr && (cfg_index == slts_pkg::CFG_PWM_PERIOD);

  // Register file; writes to unused indexes drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period               <= slts_pkg::PWM_PERIOD_RST;
      front_cfg.critical_level <= slts_pkg::CRITICAL_LEVEL_RST;
      front_cfg.low_level      <= slts_pkg::LOW_LEVEL_RST;
      front_cfg.status_divider <= slts_pkg::STATUS_DIVIDER_RST;
      front_cfg.boot_windows   <= slts_pkg::BOOT_WINDOWS_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        slts_pkg::CFG_PWM_PERIOD:     pwm_period               <= cfg_data;
        slts_pkg::CFG_CRITICAL_LEVEL: front_cfg.critical_level <= cfg_data[6:0];
        slts_pkg::CFG_LOW_LEVEL:      front_cfg.low_level      <= cfg_data[6:0];
        slts_pkg::CFG_STATUS_DIVIDER: front_cfg.status_divider <= cfg_data[3:0];
        slts_pkg::CFG_BOOT_WINDOWS:   front_cfg.boot_windows   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Front: classify each tick, advance breathing and status state
  slts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (front_cfg),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Queue: decouple the front from output stalls and flash runs
  slts_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .pop_cmd  (pop_cmd)
  );

  // Back: scale the pulse and drive result words
  slts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pwm_period (pwm_period),
    .period_wr  (period_wr),
    .q_nonempty (q_nonempty),
    .q_cmd      (pop_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
